// File: sv/sde_pkg.sv
// Shared types and constants of the DER signature encoder.
package sde_pkg;

  // DER tag and fill values.
  localparam logic [7:0] TAG_SEQUENCE = 8'h30;
  localparam logic [7:0] TAG_INTEGER  = 8'h02;
  localparam logic [7:0] PAD_BYTE     = 8'h00;
  localparam int unsigned SIGN_BIT    = 7;

  // One command from the input side to the output sequencer.
  typedef struct packed {
    logic       load;   // pass data straight to the output register
    logic       burst;  // data is the first s byte: start the header burst
    logic       rpad;   // r needs a leading zero byte
    logic       last;   // data closes the encoding
    logic [7:0] data;
  } seq_cmd_t;

endpackage

// File: sv/sde_if.sv
// Valid/ready channel interfaces for raw input words and encoded output words.
interface sde_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] raw_byte;

  modport source (output valid, output raw_byte, input ready);
  modport sink (input valid, input raw_byte, output ready);
endinterface

interface sde_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] der_byte;
  logic       last_byte;

  modport source (output valid, output der_byte, output last_byte, input ready);
  modport sink (input valid, input der_byte, input last_byte, output ready);
endinterface

// File: sv/sde_rmem.sv
// Storage for the bytes of r, one write port and one registered read port.
module sde_rmem #(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned ADDR_W = 5
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [7:0]        wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [7:0]        rd_data
);

  logic [7:0] mem_r [DEPTH];

  // Write side.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // Read side, registered: data appears in the cycle after the address.
  always_ff @(posedge clk) begin
    rd_data <= mem_r[rd_addr];
  end

endmodule

// File: sv/sde_seq.sv
// Output sequencer: walks the DER header, the stored r bytes and passes s bytes.
module sde_seq
  import sde_pkg::*;
#(
  parameter int unsigned SCALAR_BYTES = 32,
  parameter int unsigned ADDR_W = 5
) (
  input  logic              clk,
  input  logic              rst_n,
  input  seq_cmd_t          cmd,
  output logic              take_ok,
  output logic [ADDR_W-1:0] rd_addr,
  input  logic [7:0]        rd_data,
  sde_out_if.source         out_chan
);

  localparam logic [7:0]        BaseLen   = 8'(2 * SCALAR_BYTES + 4);
  localparam logic [7:0]        ScalarLen = 8'(SCALAR_BYTES);
  localparam logic [ADDR_W-1:0] LastIdx   = ADDR_W'(SCALAR_BYTES - 1);

  typedef enum logic [10:0] {
    ST_IN   = 11'b000_0000_0001,
    ST_SEQ  = 11'b000_0000_0010,
    ST_TOT  = 11'b000_0000_0100,
    ST_RTAG = 11'b000_0000_1000,
    ST_RLEN = 11'b000_0001_0000,
    ST_RPAD = 11'b000_0010_0000,
    ST_RDAT = 11'b000_0100_0000,
    ST_STAG = 11'b000_1000_0000,
    ST_SLEN = 11'b001_0000_0000,
    ST_SPAD = 11'b010_0000_0000,
    ST_S0   = 11'b100_0000_0000
  } seq_state_t;

  seq_state_t        state_r, state_nxt;
  logic [ADDR_W-1:0] ridx_r, ridx_nxt;
  logic [7:0]        s0_r, s0_nxt;
  logic              rpad_r, rpad_nxt;
  logic              spad_r, spad_nxt;
  logic              last_s0_r, last_s0_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [7:0]        out_data_r, out_data_nxt;
  logic              out_last_r, out_last_nxt;
  logic              slot_free;
  logic              load_out;
  logic [7:0]        load_data;
  logic              load_last;

  // The output register can take a word when empty or being drained.
  assign slot_free = !out_valid_r || out_chan.ready;
  assign take_ok   = (state_r == ST_IN) && slot_free;
  assign rd_addr   = ridx_nxt;

  // Sequencer: one output word per step while the output side keeps up.
  always_comb begin
    state_nxt   = state_r;
    ridx_nxt    = ridx_r;
    s0_nxt      = s0_r;
    rpad_nxt    = rpad_r;
    spad_nxt    = spad_r;
    last_s0_nxt = last_s0_r;
    load_out    = 1'b0;
    load_data   = cmd.data;
    load_last   = 1'b0;
    unique case (state_r)
      ST_IN: begin
        if (cmd.burst) begin
          s0_nxt      = cmd.data;
          rpad_nxt    = cmd.rpad;
          spad_nxt    = cmd.data[SIGN_BIT];
          last_s0_nxt = cmd.last;
          ridx_nxt    = '0;
          state_nxt   = ST_SEQ;
        end else if (cmd.load) begin
          load_out  = 1'b1;
          load_data = cmd.data;
          load_last = cmd.last;
        end
      end
      ST_SEQ: begin
        load_out  = slot_free;
        load_data = TAG_SEQUENCE;
        if (slot_free) state_nxt = ST_TOT;
      end
      ST_TOT: begin
        load_out  = slot_free;
        load_data = BaseLen + {7'd0, rpad_r} + {7'd0, spad_r};
        if (slot_free) state_nxt = ST_RTAG;
      end
      ST_RTAG: begin
        load_out  = slot_free;
        load_data = TAG_INTEGER;
        if (slot_free) state_nxt = ST_RLEN;
      end
      ST_RLEN: begin
        load_out  = slot_free;
        load_data = ScalarLen + {7'd0, rpad_r};
        if (slot_free) state_nxt = rpad_r ? ST_RPAD : ST_RDAT;
      end
      ST_RPAD: begin
        load_out  = slot_free;
        load_data = PAD_BYTE;
        if (slot_free) state_nxt = ST_RDAT;
      end
      ST_RDAT: begin
        load_out  = slot_free;
        load_data = rd_data;
        if (slot_free) begin
          if (ridx_r == LastIdx) begin
            ridx_nxt  = '0;
            state_nxt = ST_STAG;
          end else begin
            ridx_nxt = ridx_r + 1'b1;
          end
        end
      end
      ST_STAG: begin
        load_out  = slot_free;
        load_data = TAG_INTEGER;
        if (slot_free) state_nxt = ST_SLEN;
      end
      ST_SLEN: begin
        load_out  = slot_free;
        load_data = ScalarLen + {7'd0, spad_r};
        if (slot_free) state_nxt = spad_r ? ST_SPAD : ST_S0;
      end
      ST_SPAD: begin
        load_out  = slot_free;
        load_data = PAD_BYTE;
        if (slot_free) state_nxt = ST_S0;
      end
      ST_S0: begin
        load_out  = slot_free;
        load_data = s0_r;
        load_last = last_s0_r;
        if (slot_free) state_nxt = ST_IN;
      end
      default: begin
        state_nxt = ST_IN;
      end
    endcase
  end

  // Output register next values.
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = load_data;
      out_last_nxt  = load_last;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IN;
      ridx_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ridx_r      <= ridx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload state.
  always_ff @(posedge clk) begin
    s0_r       <= s0_nxt;
    rpad_r     <= rpad_nxt;
    spad_r     <= spad_nxt;
    last_s0_r  <= last_s0_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_chan.valid     = out_valid_r;
  assign out_chan.der_byte  = out_data_r;
  assign out_chan.last_byte = out_last_r;

endmodule

// File: sv/ecdsa_signature_der_encode.sv
// Top level of the DER signature encoder: position tracking, r storage, sequencer.
//
//   channel   dir  handshake     payload
//   in_chan   in   valid/ready   raw_byte[7:0]
//   out_chan  out  valid/ready   der_byte[7:0], last_byte
//
// Raw words of r, and s words after the first, are accepted when the output has room.
// The first s word starts a burst of SCALAR_BYTES+7 to SCALAR_BYTES+9 output
// words, one per cycle while out_chan keeps up, set by the sequencer stepping
// through the r store's single read port; in_chan.ready is low for the whole burst.
// Reset clears the position counter and the sequencer; r holds no reset value.
// A stall on out_chan holds the output word and stops the sequencer.
module ecdsa_signature_der_encode
  import sde_pkg::*;
#(
  parameter int unsigned SCALAR_BYTES = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  sde_in_if.sink    in_chan,
  sde_out_if.source out_chan
);

  localparam int unsigned PosW  = $clog2(2 * SCALAR_BYTES);
  localparam int unsigned AddrW = (SCALAR_BYTES > 1) ? $clog2(SCALAR_BYTES) : 1;
  localparam logic [PosW-1:0] PosS0   = PosW'(SCALAR_BYTES);
  localparam logic [PosW-1:0] PosLast = PosW'(2 * SCALAR_BYTES - 1);

  logic [PosW-1:0]  pos_r, pos_nxt;
  logic             rmsb_r, rmsb_nxt;
  logic             in_fire;
  logic             take_ok;
  logic             r_phase;
  seq_cmd_t         cmd;
  logic [AddrW-1:0] rd_addr;
  logic [7:0]       rd_data;

  assign in_chan.ready = take_ok;
  assign in_fire       = in_chan.valid && take_ok;
  assign r_phase       = (pos_r < PosS0);

  // Position counter wraps after the last s word; keep the sign of r[0].
  always_comb begin
    pos_nxt  = pos_r;
    rmsb_nxt = rmsb_r;
    if (in_fire) begin
      pos_nxt = (pos_r == PosLast) ? '0 : pos_r + 1'b1;
      if (pos_r == '0) rmsb_nxt = in_chan.raw_byte[SIGN_BIT];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else begin
      pos_r <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rmsb_r <= rmsb_nxt;
  end

  // Command to the sequencer for each accepted word past r.
  always_comb begin
    cmd.load  = in_fire && !r_phase && (pos_r != PosS0);
    cmd.burst = in_fire && (pos_r == PosS0);
    cmd.rpad  = rmsb_r;
    cmd.last  = (pos_r == PosLast);
    cmd.data  = in_chan.raw_byte;
  end

  sde_rmem #(
    .DEPTH  (SCALAR_BYTES),
    .ADDR_W (AddrW)
  ) u_rmem (
    .clk     (clk),
    .wr_en   (in_fire && r_phase),
    .wr_addr (pos_r[AddrW-1:0]),
    .wr_data (in_chan.raw_byte),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  sde_seq #(
    .SCALAR_BYTES (SCALAR_BYTES),
    .ADDR_W       (AddrW)
  ) u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .take_ok  (take_ok),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data),
    .out_chan (out_chan)
  );

  // The first s word starts a burst that holds off further input.
  a_burst_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (pos_r == PosS0)) |=> !in_chan.ready)
    else $error("input accepted right after the first s word");

  // A closing word leaves the counter at the start of a new signature.
  a_last_wraps: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.ready && out_chan.last_byte) |-> (pos_r == '0))
    else $error("closing word delivered with the counter mid-signature");

  // A word is accepted only when the output register can take its result.
  a_accept_room: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |-> (!out_chan.valid || out_chan.ready))
    else $error("input accepted while output word is stalled");

endmodule
